FILE: src/rtp_trk_pkg.sv
// ----------------------------------------------------------------------------
// rtp_trk_pkg
// Shared widths, constants and the table entry layout of the per-subflow
// RTP receive tracker.
// ----------------------------------------------------------------------------
package rtp_trk_pkg;

  // Field widths of one packet beat and one result beat.
  localparam int FLOW_ID_W = 8;
  localparam int SEQ_W     = 16;
  localparam int BYTES_W   = 16;
  localparam int STAMP_W   = 32;
  localparam int JIT_W     = 32;
  localparam int PKT_W     = 32;
  localparam int BYTE_CNT_W = 48;

  // Default number of subflow table entries.
  localparam int FLOWS_DEF = 256;

  // Serial-number half range, jitter gain shift (divide by 32) and the
  // shift that gives the count of 16-bit packet counter wraps.
  localparam logic [SEQ_W-1:0] HALF_SEQ = 16'h8000;
  localparam int JITTER_SHIFT = 5;
  localparam int CYCLE_SHIFT  = 16;

  // One table entry per subflow.
  typedef struct packed {
    logic [SEQ_W-1:0]      highest;
    logic [STAMP_W-1:0]    arrival;
    logic [STAMP_W-1:0]    sender;
    logic [JIT_W-1:0]      jitter;
    logic [PKT_W-1:0]      pkt_count;
    logic [BYTE_CNT_W-1:0] byte_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/rtp_trk_in_if.sv
// ----------------------------------------------------------------------------
// rtp_trk_in_if
// Packet channel: valid/ready handshake carrying one received packet a beat.
// ----------------------------------------------------------------------------
interface rtp_trk_in_if
  import rtp_trk_pkg::*;
  ();

  logic                 valid;
  logic                 ready;
  logic [FLOW_ID_W-1:0] flow_id;
  logic [SEQ_W-1:0]     flow_seq;
  logic [BYTES_W-1:0]   payload_bytes;
  logic [STAMP_W-1:0]   arrival_stamp;
  logic [STAMP_W-1:0]   sender_stamp;

  modport source (
    output valid, flow_id, flow_seq, payload_bytes, arrival_stamp, sender_stamp,
    input  ready
  );

  modport sink (
    input  valid, flow_id, flow_seq, payload_bytes, arrival_stamp, sender_stamp,
    output ready
  );

endinterface

FILE: src/rtp_trk_out_if.sv
// ----------------------------------------------------------------------------
// rtp_trk_out_if
// Result channel: valid/ready handshake carrying one statistics result a beat.
// ----------------------------------------------------------------------------
interface rtp_trk_out_if
  import rtp_trk_pkg::*;
  ();

  logic                  valid;
  logic                  ready;
  logic                  tracked;
  logic                  first_packet;
  logic                  late;
  logic [STAMP_W-1:0]    skew;
  logic [JIT_W-1:0]      jitter_now;
  logic [SEQ_W-1:0]      lost_first;
  logic [SEQ_W-1:0]      lost_count;
  logic [SEQ_W-1:0]      highest_now;
  logic [PKT_W-1:0]      packet_total;
  logic [SEQ_W-1:0]      wrap_cycles;
  logic [BYTE_CNT_W-1:0] byte_total;

  modport source (
    output valid, tracked, first_packet, late, skew, jitter_now, lost_first,
           lost_count, highest_now, packet_total, wrap_cycles, byte_total,
    input  ready
  );

  modport sink (
    input  valid, tracked, first_packet, late, skew, jitter_now, lost_first,
           lost_count, highest_now, packet_total, wrap_cycles, byte_total,
    output ready
  );

endinterface

FILE: src/per_flow_rtp_receive_tracker_unit.sv
// ----------------------------------------------------------------------------
// per_flow_rtp_receive_tracker_unit
// Per-subflow RTP receive statistics: jitter, loss, late packets and counts,
// kept in one table RAM indexed by subflow.
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------------
//   in_ch    | in  | flow_id, flow_seq, payload_bytes, arrival/sender stamps
//   out_ch   | out | tracked, first/late flags, skew, jitter, loss, counts
//
// Each packet passes through accept with the table read, a skew and
// sequence stage on the read data, then the jitter update with write-back.
// The next packet is accepted in the cycle after write-back, so one packet
// is in flight at a time and no forwarding is needed.
// Reset clears the per-subflow seen bits at once; no clearing pass is run.
// One packet can be accepted while a result waits in the output register;
// that packet then holds in the jitter stage, and the input stays blocked,
// until the waiting result beat is taken.
// ----------------------------------------------------------------------------
module per_flow_rtp_receive_tracker_unit
  import rtp_trk_pkg::*;
#(
  parameter int FLOWS = FLOWS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rtp_trk_in_if.sink   in_ch,
  rtp_trk_out_if.source out_ch
);

  localparam int IDX_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SKEW,
    S_JIT
  } state_t;

  state_t state_r;

  // Captured packet.
  logic [IDX_W-1:0]   idx_r;
  logic               tracked_r;
  logic [SEQ_W-1:0]   seq_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [STAMP_W-1:0] arr_r;
  logic [STAMP_W-1:0] snd_r;

  // Seen bit per subflow.
  logic [FLOWS-1:0] seen_r;

  // Skew stage results.
  logic                  first_r;
  logic                  late_r;
  logic [STAMP_W-1:0]    skew_r;
  logic [JIT_W-1:0]      jit_old_r;
  logic [SEQ_W-1:0]      lost_first_r;
  logic [SEQ_W-1:0]      lost_cnt_r;
  logic [SEQ_W-1:0]      highest_r;
  logic [PKT_W-1:0]      pkt_r;
  logic [BYTE_CNT_W-1:0] bcnt_r;

  // Output register.
  logic                  out_valid_r;
  logic                  o_tracked_r;
  logic                  o_first_r;
  logic                  o_late_r;
  logic [STAMP_W-1:0]    o_skew_r;
  logic [JIT_W-1:0]      o_jit_r;
  logic [SEQ_W-1:0]      o_lost_first_r;
  logic [SEQ_W-1:0]      o_lost_cnt_r;
  logic [SEQ_W-1:0]      o_highest_r;
  logic [PKT_W-1:0]      o_pkt_r;
  logic [BYTE_CNT_W-1:0] o_bcnt_r;

  // Handshake terms.
  logic in_fire;
  logic in_tracked;
  logic jit_done;

  // Table RAM ports.
  logic             mem_we;
  entry_t           mem_wdata;
  entry_t           mem_rdata;
  logic [ENTRY_W-1:0] mem_rdata_raw;

  // Skew stage next values.
  logic                  first_nxt;
  logic                  late_nxt;
  logic [STAMP_W-1:0]    skew_nxt;
  logic [JIT_W-1:0]      jit_old_nxt;
  logic [SEQ_W-1:0]      lost_first_nxt;
  logic [SEQ_W-1:0]      lost_cnt_nxt;
  logic [SEQ_W-1:0]      highest_nxt;
  logic [PKT_W-1:0]      pkt_nxt;
  logic [BYTE_CNT_W-1:0] bcnt_nxt;

  // Jitter stage next value.
  logic [JIT_W-1:0] jit_nxt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_tracked  = (in_ch.flow_id != '0) &&
                       ({1'b0, in_ch.flow_id} < (FLOW_ID_W + 1)'(FLOWS));
  assign jit_done    = (state_r == S_JIT) && (!out_valid_r || out_ch.ready);

  // Subflow table: read at accept, written back when the jitter stage ends.
  rtp_trk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOWS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx_r),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (in_ch.flow_id[IDX_W-1:0]),
    .rdata (mem_rdata_raw)
  );

  assign mem_rdata = entry_t'(mem_rdata_raw);
  assign mem_we    = jit_done && tracked_r;

  always_comb begin
    mem_wdata            = '0;
    mem_wdata.highest    = highest_r;
    mem_wdata.arrival    = arr_r;
    mem_wdata.sender     = snd_r;
    mem_wdata.jitter     = jit_nxt;
    mem_wdata.pkt_count  = pkt_r;
    mem_wdata.byte_count = bcnt_r;
  end

  // Skew, sequence order and counters from the table entry.
  always_comb begin
    logic             seen;
    logic [STAMP_W-1:0] dr;
    logic [STAMP_W-1:0] ds;
    logic [SEQ_W-1:0] exp_seq;
    logic [SEQ_W-1:0] ahead;
    logic             gap;

    seen    = tracked_r && seen_r[idx_r];
    dr      = arr_r - mem_rdata.arrival;
    ds      = snd_r - mem_rdata.sender;
    exp_seq = mem_rdata.highest + SEQ_W'(1);
    ahead   = seq_r - exp_seq;
    gap     = seen && (ahead != '0) && !ahead[SEQ_W-1];

    first_nxt      = tracked_r && !seen;
    late_nxt       = seen && (ahead != '0) && (ahead != HALF_SEQ) && ahead[SEQ_W-1];
    skew_nxt       = !seen ? '0 : ((dr >= ds) ? (dr - ds) : (ds - dr));
    jit_old_nxt    = seen ? mem_rdata.jitter : '0;
    lost_first_nxt = gap ? exp_seq : '0;
    lost_cnt_nxt   = gap ? ahead : '0;
    highest_nxt    = (seen && late_nxt) ? mem_rdata.highest : seq_r;
    pkt_nxt        = seen ? (mem_rdata.pkt_count + PKT_W'(1)) : PKT_W'(1);
    bcnt_nxt       = seen ? (mem_rdata.byte_count + BYTE_CNT_W'(bytes_r))
                          : BYTE_CNT_W'(bytes_r);
  end

  // Jitter moves by (skew - jitter) / 32, rounded toward zero.
  always_comb begin
    logic signed [JIT_W:0] diff;
    logic signed [JIT_W:0] step;
    logic                  corr;

    diff    = $signed({1'b0, skew_r}) - $signed({1'b0, jit_old_r});
    step    = diff >>> JITTER_SHIFT;
    corr    = diff[JIT_W] && (diff[JITTER_SHIFT-1:0] != '0);
    jit_nxt = jit_old_r + step[JIT_W-1:0] + JIT_W'(corr);
  end

  // Sequencer, captured packet, stage registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            idx_r     <= in_ch.flow_id[IDX_W-1:0];
            tracked_r <= in_tracked;
            seq_r     <= in_ch.flow_seq;
            bytes_r   <= in_ch.payload_bytes;
            arr_r     <= in_ch.arrival_stamp;
            snd_r     <= in_ch.sender_stamp;
            state_r   <= S_SKEW;
          end
        end
        S_SKEW: begin
          first_r      <= first_nxt;
          late_r       <= late_nxt;
          skew_r       <= skew_nxt;
          jit_old_r    <= jit_old_nxt;
          lost_first_r <= lost_first_nxt;
          lost_cnt_r   <= lost_cnt_nxt;
          highest_r    <= highest_nxt;
          pkt_r        <= pkt_nxt;
          bcnt_r       <= bcnt_nxt;
          state_r      <= S_JIT;
        end
        S_JIT: begin
          if (jit_done) begin
            out_valid_r    <= 1'b1;
            o_tracked_r    <= tracked_r;
            o_first_r      <= first_r;
            o_late_r       <= late_r;
            o_skew_r       <= tracked_r ? skew_r : '0;
            o_jit_r        <= tracked_r ? jit_nxt : '0;
            o_lost_first_r <= tracked_r ? lost_first_r : '0;
            o_lost_cnt_r   <= tracked_r ? lost_cnt_r : '0;
            o_highest_r    <= tracked_r ? highest_r : '0;
            o_pkt_r        <= tracked_r ? pkt_r : '0;
            o_bcnt_r       <= tracked_r ? bcnt_r : '0;
            if (tracked_r) begin
              seen_r[idx_r] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tracked      = o_tracked_r;
  assign out_ch.first_packet = o_first_r;
  assign out_ch.late         = o_late_r;
  assign out_ch.skew         = o_skew_r;
  assign out_ch.jitter_now   = o_jit_r;
  assign out_ch.lost_first   = o_lost_first_r;
  assign out_ch.lost_count   = o_lost_cnt_r;
  assign out_ch.highest_now  = o_highest_r;
  assign out_ch.packet_total = o_pkt_r;
  assign out_ch.wrap_cycles  = o_pkt_r[CYCLE_SHIFT +: SEQ_W];
  assign out_ch.byte_total   = o_bcnt_r;

  // The table is written back only at the end of a tracked packet's jitter stage.
  a_write_only_in_jit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_JIT) && tracked_r)
    else $error("table write outside the jitter stage");

  // A new result appears only as a packet leaves the jitter stage.
  a_result_from_jit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_JIT)
    else $error("result raised without a finished packet");

  // An accepted packet moves to the skew stage in the next cycle.
  a_accept_to_skew: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_SKEW)
    else $error("accepted packet did not enter the skew stage");

  // A late or first packet never reports loss.
  a_loss_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (o_late_r || o_first_r)) |-> (o_lost_cnt_r == '0))
    else $error("loss reported on a late or first packet");

  // Flags only on tracked subflows, and a first packet is never late.
  a_flags_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (o_first_r || o_late_r)) |-> o_tracked_r && !(o_first_r && o_late_r))
    else $error("inconsistent result flags");

endmodule

FILE: src/rtp_trk_ram.sv
// ----------------------------------------------------------------------------
// rtp_trk_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtp_trk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the per-subflow RTP receive tracker. A short table
// of directed packets covers the field extremes and the sequence corner
// cases: untracked subflow, first packet, late packet, half-way sequence,
// widest gap and maximum skew. Streams of well-formed packets with random
// content follow, on a handful of busy subflows, mixed with noise. Every
// result beat is compared field by field against an in-bench model of the
// subflow table, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rtp_trk_pkg::*;

  localparam int          NUM_FLOWS    = FLOWS_DEF;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          HOLD_CYCLES  = 80;
  localparam longint      JITTER_DIV   = longint'(1) << JITTER_SHIFT;
  localparam int unsigned BUSY_FLOWS [8] = '{1, 2, 3, 7, 64, 129, 200, 255};

  // One packet beat and one result beat, in port order.
  typedef struct packed {
    logic [FLOW_ID_W-1:0] flow_id;
    logic [SEQ_W-1:0]     flow_seq;
    logic [BYTES_W-1:0]   payload_bytes;
    logic [STAMP_W-1:0]   arrival_stamp;
    logic [STAMP_W-1:0]   sender_stamp;
  } pkt_t;

  typedef struct packed {
    logic                  tracked;
    logic                  first_packet;
    logic                  late;
    logic [STAMP_W-1:0]    skew;
    logic [JIT_W-1:0]      jitter_now;
    logic [SEQ_W-1:0]      lost_first;
    logic [SEQ_W-1:0]      lost_count;
    logic [SEQ_W-1:0]      highest_now;
    logic [PKT_W-1:0]      packet_total;
    logic [SEQ_W-1:0]      wrap_cycles;
    logic [BYTE_CNT_W-1:0] byte_total;
  } result_t;

  // A directed row carries its result only where it is plain to see.
  typedef struct packed {
    logic    fixed_result;
    pkt_t    pkt;
    result_t want;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  localparam stim_row_t DIRECTED_ROWS [24] = '{
    // Untracked subflow with every field at its maximum, then at zero.
    '{1'b1, '{8'h00, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, NO_RES},
    '{1'b1, '{8'h00, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000}, NO_RES},
    // First packet of the top subflow, at the top of the sequence space.
    '{1'b1, '{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000},
            '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hFFFF, 32'd1, 16'h0,
              48'hFFFF}},
    // In-order across the sequence wrap, a gap, a late one, half-way.
    '{1'b0, '{8'hFF, 16'h0000, 16'h0001, 32'h0000_0000, 32'h0000_0001}, NO_RES},
    '{1'b0, '{8'hFF, 16'h0005, 16'h0010, 32'h0000_0100, 32'h0000_0101}, NO_RES},
    '{1'b0, '{8'hFF, 16'h0002, 16'h0020, 32'h0000_0200, 32'h0000_0150}, NO_RES},
    '{1'b0, '{8'hFF, 16'h8006, 16'h0030, 32'h0000_0300, 32'h0000_0250}, NO_RES},
    // Widest gap, then the oldest sequence that still counts as late.
    '{1'b0, '{8'hFF, 16'h0006, 16'h0040, 32'h0000_0400, 32'h0000_0350}, NO_RES},
    '{1'b0, '{8'hFF, 16'h8008, 16'h0050, 32'h0000_1000, 32'h0000_2000}, NO_RES},
    // Maximum skew both ways, then zero skew so the jitter steps down.
    '{1'b0, '{8'hFF, 16'h0007, 16'h0060, 32'h0000_0FFF, 32'h0000_2000}, NO_RES},
    '{1'b0, '{8'hFF, 16'h0008, 16'h0070, 32'h0000_0FFF, 32'h0000_1FFF}, NO_RES},
    '{1'b0, '{8'hFF, 16'h0009, 16'hFFFF, 32'h0000_1000, 32'h0000_2000}, NO_RES},
    '{1'b0, '{8'hFF, 16'h000A, 16'hFFFF, 32'h0000_1001, 32'h0000_2001}, NO_RES},
    // Lowest tracked subflow: first packet, in order, duplicate.
    '{1'b1, '{8'h01, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000},
            '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0000, 32'd1, 16'h0,
              48'h0}},
    '{1'b0, '{8'h01, 16'h0001, 16'h0000, 32'h0000_0000, 32'h0000_0000}, NO_RES},
    '{1'b0, '{8'h01, 16'h0001, 16'h0005, 32'h0000_0010, 32'h0000_0010}, NO_RES},
    // Mid subflow: small skews where the jitter step truncates.
    '{1'b1, '{8'h80, 16'h8000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF},
            '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h8000, 32'd1, 16'h0,
              48'h8000}},
    '{1'b0, '{8'h80, 16'h8001, 16'h0100, 32'h8000_0010, 32'h8000_0000}, NO_RES},
    '{1'b0, '{8'h80, 16'h8002, 16'h0100, 32'h8000_0050, 32'h8000_0001}, NO_RES},
    '{1'b0, '{8'h01, 16'h8002, 16'h0001, 32'h0000_0020, 32'h0000_0020}, NO_RES},
    // Alternating bit patterns on two fresh subflows.
    '{1'b1, '{8'hAA, 16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA},
            '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h5555, 32'd1, 16'h0,
              48'hAAAA}},
    '{1'b1, '{8'h55, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555},
            '{1'b1, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 16'hAAAA, 32'd1, 16'h0,
              48'h5555}},
    '{1'b1, '{8'h00, 16'h1234, 16'h0BEE, 32'h1357_9BDF, 32'h0246_8ACE}, NO_RES},
    '{1'b0, '{8'hAA, 16'h5556, 16'h0001, 32'h5555_6555, 32'hAAAA_BAAA}, NO_RES}
  };

  logic clk;
  logic rst_n;

  rtp_trk_in_if  in_ch ();
  rtp_trk_out_if out_ch ();

  per_flow_rtp_receive_tracker_unit #(
    .FLOWS (NUM_FLOWS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model of the subflow table.
  bit                  flow_seen    [NUM_FLOWS];
  bit [SEQ_W-1:0]      flow_highest [NUM_FLOWS];
  bit [STAMP_W-1:0]    flow_arrival [NUM_FLOWS];
  bit [STAMP_W-1:0]    flow_sender  [NUM_FLOWS];
  bit [JIT_W-1:0]      flow_jitter  [NUM_FLOWS];
  bit [PKT_W-1:0]      flow_pkts    [NUM_FLOWS];
  bit [BYTE_CNT_W-1:0] flow_bytes   [NUM_FLOWS];

  // Packet generator state for the well-formed streams.
  bit [SEQ_W-1:0]   gen_next_seq [256];
  bit [STAMP_W-1:0] gen_arrival  [256];
  bit [STAMP_W-1:0] gen_sender   [256];

  result_t     expected_stats_q [$];
  int unsigned stat_mismatches = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  bit          cur_fixed = 1'b0;
  result_t     cur_want = '0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Updates the subflow table for one packet and returns its statistics.
  function automatic result_t track_packet(pkt_t p);
    result_t          r;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] ahead;
    logic [STAMP_W-1:0] d_arr;
    logic [STAMP_W-1:0] d_snd;
    longint           diff;
    int unsigned      fid;
    r   = '0;
    fid = 32'(p.flow_id);
    if (fid == 0 || fid >= NUM_FLOWS) return r;
    r.tracked = 1'b1;
    if (!flow_seen[fid]) begin
      flow_seen[fid]    = 1'b1;
      flow_highest[fid] = p.flow_seq;
      flow_arrival[fid] = p.arrival_stamp;
      flow_sender[fid]  = p.sender_stamp;
      flow_pkts[fid]    = 1;
      flow_bytes[fid]   = BYTE_CNT_W'(p.payload_bytes);
      r.first_packet    = 1'b1;
    end else begin
      // Skew from the wrapped deltas; jitter moves 1/32 of the way, toward zero.
      d_arr  = p.arrival_stamp - flow_arrival[fid];
      d_snd  = p.sender_stamp - flow_sender[fid];
      r.skew = (d_arr >= d_snd) ? d_arr - d_snd : d_snd - d_arr;
      diff   = $signed({32'd0, r.skew}) - $signed({32'd0, flow_jitter[fid]});
      flow_jitter[fid]  = flow_jitter[fid] + JIT_W'(diff / JITTER_DIV);
      flow_arrival[fid] = p.arrival_stamp;
      flow_sender[fid]  = p.sender_stamp;
      flow_pkts[fid]    = flow_pkts[fid] + 1;
      flow_bytes[fid]   = flow_bytes[fid] + BYTE_CNT_W'(p.payload_bytes);
      // Serial-number order against the next expected sequence.
      next_seq = flow_highest[fid] + 16'd1;
      ahead    = p.flow_seq - next_seq;
      if (ahead > HALF_SEQ) begin
        r.late = 1'b1;
      end else begin
        if (ahead != 0 && ahead != HALF_SEQ) begin
          r.lost_first = next_seq;
          r.lost_count = ahead;
        end
        flow_highest[fid] = p.flow_seq;
      end
    end
    r.jitter_now   = flow_jitter[fid];
    r.highest_now  = flow_highest[fid];
    r.packet_total = flow_pkts[fid];
    r.wrap_cycles  = SEQ_W'(flow_pkts[fid] >> CYCLE_SHIFT);
    r.byte_total   = flow_bytes[fid];
    return r;
  endfunction

  function automatic string show_stats(result_t r);
    return $sformatf({"trk=%0b fst=%0b late=%0b skew=%h jit=%h lost=%h/%0d hi=%h",
                      " pkts=%0d wrap=%0d bytes=%h"},
                     r.tracked, r.first_packet, r.late, r.skew, r.jitter_now,
                     r.lost_first, r.lost_count, r.highest_now, r.packet_total,
                     r.wrap_cycles, r.byte_total);
  endfunction

  // Offers one packet in bursts with random gaps and holds it until accepted.
  task automatic send_packet(pkt_t p, bit fixed, result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cur_fixed = fixed;
    cur_want  = want;
    in_ch.valid         <= 1'b1;
    in_ch.flow_id       <= p.flow_id;
    in_ch.flow_seq      <= p.flow_seq;
    in_ch.payload_bytes <= p.payload_bytes;
    in_ch.arrival_stamp <= p.arrival_stamp;
    in_ch.sender_stamp  <= p.sender_stamp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Result sink: random stall patterns, all-ready stretches, and a long
  // hold-off when asked for.
  initial begin : result_sink
    int unsigned      hold_left;
    int unsigned      pos;
    logic [15:0]      pat;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    pos          = 0;
    pat          = '1;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (pos == 0) begin
          pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end
        out_ch.ready <= pat[pos];
        pos = (pos + 1) % 16;
      end
    end
  end

  // Predict on every accepted packet beat, check every accepted result beat.
  always @(posedge clk) begin : stats_check
    pkt_t    pkt;
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        pkt  = '{in_ch.flow_id, in_ch.flow_seq, in_ch.payload_bytes,
                 in_ch.arrival_stamp, in_ch.sender_stamp};
        want = track_packet(pkt);
        if (cur_fixed) want = cur_want;
        expected_stats_q.push_back(want);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.tracked, out_ch.first_packet, out_ch.late, out_ch.skew,
                out_ch.jitter_now, out_ch.lost_first, out_ch.lost_count,
                out_ch.highest_now, out_ch.packet_total, out_ch.wrap_cycles,
                out_ch.byte_total};
        if (expected_stats_q.size() == 0) begin
          stat_mismatches++;
          if (stat_mismatches <= 10) begin
            $display("unexpected result beat: %s", show_stats(got));
          end
        end else begin
          want = expected_stats_q.pop_front();
          if (got !== want) begin
            stat_mismatches++;
            if (stat_mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", show_stats(want));
              $display("  actual   %s", show_stats(got));
            end
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random streams.
  initial begin : stimulus
    pkt_t        p;
    int unsigned n;
    int unsigned kind;
    int unsigned sub;
    int unsigned fid;
    int unsigned step;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.flow_id       = '0;
    in_ch.flow_seq      = '0;
    in_ch.payload_bytes = '0;
    in_ch.arrival_stamp = '0;
    in_ch.sender_stamp  = '0;
    for (n = 0; n < 256; n++) begin
      gen_next_seq[n] = 16'($urandom);
      gen_arrival[n]  = $urandom;
      gen_sender[n]   = $urandom;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (n = 0; n < $size(DIRECTED_ROWS); n++) begin
      send_packet(DIRECTED_ROWS[n].pkt, DIRECTED_ROWS[n].fixed_result,
                  DIRECTED_ROWS[n].want);
    end

    // Random streams.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Long receiver hold-off while packets keep coming.
      if (n == 150 || n == 520) hold_req = 1'b1;
      // Let everything drain before going on.
      if (n == 300 || n == 650) begin
        in_ch.valid <= 1'b0;
        while (expected_stats_q.size() != 0) @(negedge clk);
        @(negedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // Untracked subflow, random content.
        p = '{8'h00, 16'($urandom), 16'($urandom), $urandom, $urandom};
      end else if (kind < 22) begin
        // Noise on any subflow.
        p = '{8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom), $urandom, $urandom};
      end else begin
        // Well-formed stream on a busy subflow.
        fid = BUSY_FLOWS[$urandom_range(0, 7)];
        sub = $urandom_range(0, 99);
        p.flow_id = 8'(fid);
        if (sub < 75) begin
          p.flow_seq = gen_next_seq[fid];
        end else if (sub < 87) begin
          p.flow_seq = gen_next_seq[fid] + 16'($urandom_range(1, 5));
        end else if (sub < 95) begin
          p.flow_seq = gen_next_seq[fid] - 16'($urandom_range(1, 20));
        end else if (sub < 97) begin
          p.flow_seq = gen_next_seq[fid] + HALF_SEQ;
        end else begin
          p.flow_seq = gen_next_seq[fid] + 16'($urandom_range(100, 32767));
        end
        // Late packets leave the expected sequence where it was.
        if (sub < 87 || sub >= 95) gen_next_seq[fid] = p.flow_seq + 16'd1;
        step = $urandom_range(1, 4000);
        gen_sender[fid]  = gen_sender[fid] + step;
        gen_arrival[fid] = gen_arrival[fid] + step + $urandom_range(0, 800) - 400;
        p.sender_stamp   = gen_sender[fid];
        p.arrival_stamp  = gen_arrival[fid];
        p.payload_bytes  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(40, 1500));
      end
      send_packet(p, 1'b0, NO_RES);
    end

    // Drain and settle.
    in_ch.valid <= 1'b0;
    while (expected_stats_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stat_mismatches == 0 && expected_stats_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rtp_trk_pkg.sv
src/rtp_trk_in_if.sv
src/rtp_trk_out_if.sv
src/rtp_trk_ram.sv
src/per_flow_rtp_receive_tracker_unit.sv
tb/testbench.sv
